// ----- sv/rgb_palette_index_packer_unit_assert.svh -----
// assertion macros shared by the palette index packer modules
`ifndef RGB_PALETTE_INDEX_PACKER_UNIT_ASSERT_SVH
`define RGB_PALETTE_INDEX_PACKER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RPIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rpip check failed");

// next-cycle implication, checked out of reset
`define RPIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rpip check failed");

`endif

// ----- sv/rpip_pkg.sv -----
// types, constants and colour reduction for the palette index packer
`timescale 1ns / 1ps

package rpip_pkg;

    // default number of palette entries
    localparam int PALETTE_DEPTH_DEF = 256;
    // entries searched in 4bpp mode
    localparam int ENTRIES_4BPP = 16;

    typedef enum logic {
        KIND_PALETTE_WRITE = 1'b0,
        KIND_PIXEL         = 1'b1
    } t_kind;

    typedef enum logic {
        FMT_4BPP = 1'b0,
        FMT_8BPP = 1'b1
    } t_fmt;

    // transaction travelling along the cell chain
    typedef struct packed {
        logic        vld;
        t_kind       kind;
        logic [7:0]  idx;
        logic [14:0] colour;
        logic        found;
        logic [7:0]  hit;
    } t_query;

    // floor(x * 31 / 255) via reciprocal of 255 with rounding correction
    function automatic logic [4:0] to_five(input logic [7:0] x);
        logic [12:0] y;
        logic [13:0] t;
        begin
            y = {5'd0, x} * 13'd31;
            t = {1'b0, y} + {9'd0, y[12:8]} + 14'd1;
            to_five = t[12:8];
        end
    endfunction

    // blue in the top five bits, red in the bottom five
    function automatic logic [14:0] reduce_colour(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
        begin
            reduce_colour = {to_five(b), to_five(g), to_five(r)};
        end
    endfunction

endpackage

// ----- sv/rpip_cell.sv -----
// one palette entry with its compare stage in the search chain
`timescale 1ns / 1ps
`include "rgb_palette_index_packer_unit_assert.svh"

module rpip_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_fmt,
    input  rpip_pkg::t_query i_q,
    output rpip_pkg::t_query o_q
);
    import rpip_pkg::*;

    localparam logic [7:0] CELL_ID = 8'(CELL_IDX);

    logic [15:0] r_entry;
    t_query      r_q;
    t_query      n_q;
    logic        in_range;
    logic        match;

    // this entry is searched only inside the active palette size
    assign in_range = (t_fmt'(i_fmt) == FMT_8BPP) || (CELL_ID < 8'(ENTRIES_4BPP));
    assign match    = r_entry[15] && (r_entry[14:0] == i_q.colour) && in_range;

    // pass the transaction on, marking the first hit
    always_comb begin
        n_q = i_q;
        if (i_q.vld && (i_q.kind == KIND_PIXEL) && !i_q.found && match) begin
            n_q.found = 1'b1;
            n_q.hit   = CELL_ID;
        end
    end

    // pipeline stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_adv) begin
            r_q <= n_q;
        end
    end

    // entry storage, written as a palette write passes by
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_adv && i_q.vld && (i_q.kind == KIND_PALETTE_WRITE)
                     && (i_q.idx == CELL_ID)) begin
            r_entry <= {1'b1, i_q.colour};
        end
    end

    assign o_q = r_q;

    `RPIP_ASSERT_NOW(a_hit_not_beyond_cell, i_clk, i_rst_n,
        r_q.vld && r_q.found, r_q.hit <= CELL_ID)
    `RPIP_ASSERT_NOW(a_hit_in_4bpp_range, i_clk, i_rst_n,
        r_q.vld && r_q.found && (t_fmt'(i_fmt) == FMT_4BPP),
        r_q.hit < 8'(ENTRIES_4BPP))
    `RPIP_ASSERT_NEXT(a_first_hit_kept, i_clk, i_rst_n,
        i_adv && i_q.vld && i_q.found,
        r_q.found && (r_q.hit == $past(i_q.hit)))

endmodule

// ----- sv/rpip_pack.sv -----
// nibble pairing and result register at the end of the chain
`timescale 1ns / 1ps
`include "rgb_palette_index_packer_unit_assert.svh"

module rpip_pack (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fmt,
    input  rpip_pkg::t_query i_q,
    input  logic             i_out_ready,
    output logic             o_adv,
    output logic             o_out_valid,
    output logic [7:0]       o_packed_byte,
    output logic             o_not_found
);
    import rpip_pkg::*;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_nf;
    logic [3:0] r_pending;
    logic       r_half;
    logic       n_out_valid;
    logic [7:0] n_out_byte;
    logic       n_out_nf;
    logic [3:0] n_pending;
    logic       n_half;
    logic       adv;
    logic       pix;

    // chain moves unless a result is stuck in the output register
    assign adv = !(r_out_valid && !i_out_ready);
    assign pix = adv && i_q.vld && (i_q.kind == KIND_PIXEL);

    // result and pairing update
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_out_nf    = r_out_nf;
        n_pending   = r_pending;
        n_half      = r_half;
        if (pix) begin
            if (!i_q.found) begin
                n_pending   = 4'd0;
                n_half      = 1'b0;
                n_out_valid = 1'b1;
                n_out_byte  = 8'd0;
                n_out_nf    = 1'b1;
            end else if (t_fmt'(i_fmt) == FMT_8BPP) begin
                n_pending   = 4'd0;
                n_half      = 1'b0;
                n_out_valid = 1'b1;
                n_out_byte  = i_q.hit;
                n_out_nf    = 1'b0;
            end else if (!r_half) begin
                n_pending   = i_q.hit[3:0];
                n_half      = 1'b1;
            end else begin
                n_pending   = 4'd0;
                n_half      = 1'b0;
                n_out_valid = 1'b1;
                n_out_byte  = {i_q.hit[3:0], r_pending};
                n_out_nf    = 1'b0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_byte  <= '0;
            r_out_nf    <= 1'b0;
            r_pending   <= '0;
            r_half      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_out_byte  <= n_out_byte;
            r_out_nf    <= n_out_nf;
            r_pending   <= n_pending;
            r_half      <= n_half;
        end
    end

    assign o_adv         = adv;
    assign o_out_valid   = r_out_valid;
    assign o_packed_byte = r_out_byte;
    assign o_not_found   = r_out_nf;

    `RPIP_ASSERT_NOW(a_not_found_byte_zero, i_clk, i_rst_n,
        r_out_valid && r_out_nf, r_out_byte == 8'd0)
    `RPIP_ASSERT_NEXT(a_8bpp_leaves_no_half, i_clk, i_rst_n,
        pix && (t_fmt'(i_fmt) == FMT_8BPP), !r_half && (r_pending == 4'd0))
    `RPIP_ASSERT_NEXT(a_even_pixel_held, i_clk, i_rst_n,
        pix && i_q.found && (t_fmt'(i_fmt) == FMT_4BPP) && !r_half,
        r_half && (r_out_valid == $past(r_out_valid && !i_out_ready)))

endmodule

// ----- sv/rgb_palette_index_packer_unit.sv -----
// Palette index packer: turns 8-bit RGB pixels into 4bpp or 8bpp palette index bytes.
// Each palette entry lives in its own cell of a chain PALETTE_DEPTH cells long; every
// transaction (palette write or pixel) walks the chain one cell per cycle while it
// advances, so writes and lookups stay in order. The block takes one transaction per
// cycle while the output is free; a pixel's result passes through every cell register
// and then the output register, and a result waiting there holds the whole chain.
// Palette writes give no result, and neither does the even pixel of a 4bpp pair. After
// reset every palette entry is invalid at once; no clearing pass is needed.
// pixel_format is written through i_cfg_wr_en and should only change while the block
// holds no transaction in flight.
`timescale 1ns / 1ps

module rgb_palette_index_packer_unit #(
    parameter int PALETTE_DEPTH = rpip_pkg::PALETTE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_kind,
    input  logic [7:0] i_entry_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_packed_byte,
    output logic       o_not_found
);
    import rpip_pkg::*;

    logic   r_fmt;
    logic   adv;
    t_query q_chain [PALETTE_DEPTH+1];

    // format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_4BPP;
        end else if (i_cfg_wr_en) begin
            r_fmt <= i_cfg_wr_data;
        end
    end

    // incoming transaction with its reduced colour
    always_comb begin
        q_chain[0].vld    = i_in_valid;
        q_chain[0].kind   = t_kind'(i_kind);
        q_chain[0].idx    = i_entry_index;
        q_chain[0].colour = reduce_colour(i_red, i_green, i_blue);
        q_chain[0].found  = 1'b0;
        q_chain[0].hit    = 8'd0;
    end

    assign o_in_ready = adv;

    // chain of palette cells
    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        rpip_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_fmt   (r_fmt),
            .i_q     (q_chain[g]),
            .o_q     (q_chain[g+1])
        );
    end

    // pairing and output register
    rpip_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fmt         (r_fmt),
        .i_q           (q_chain[PALETTE_DEPTH]),
        .i_out_ready   (i_out_ready),
        .o_adv         (adv),
        .o_out_valid   (o_out_valid),
        .o_packed_byte (o_packed_byte),
        .o_not_found   (o_not_found)
    );

endmodule

// ----- bench/tb.sv -----
// self-checking testbench for the rgb palette index packer
`timescale 1ns / 1ps

module tb;
    import rpip_pkg::*;

    localparam int DEPTH       = PALETTE_DEPTH_DEF;
    // chain length plus output register, with some margin
    localparam int SETTLE      = DEPTH + 16;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 700;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       not_found;
    } t_index_result;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic       o_in_ready;
    logic       i_kind        = 1'b0;
    logic [7:0] i_entry_index = 8'd0;
    logic [7:0] i_red         = 8'd0;
    logic [7:0] i_green       = 8'd0;
    logic [7:0] i_blue        = 8'd0;
    logic       o_out_valid;
    logic       i_out_ready   = 1'b0;
    logic [7:0] o_packed_byte;
    logic       o_not_found;

    rgb_palette_index_packer_unit #(
        .PALETTE_DEPTH(DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_kind(i_kind),
        .i_entry_index(i_entry_index),
        .i_red(i_red),
        .i_green(i_green),
        .i_blue(i_blue),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_packed_byte(o_packed_byte),
        .o_not_found(o_not_found)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state: palette, half-filled byte and pixel format
    logic [15:0]   colour_table [DEPTH];
    logic [3:0]    held_nibble = 4'd0;
    bit            pair_open   = 1'b0;
    t_fmt          cur_format  = FMT_4BPP;
    t_index_result expected_bytes [$];

    // stimulus side memory of what each entry was written with
    logic [23:0] known_rgb [DEPTH];
    bit          known_set [DEPTH];

    int err_count    = 0;
    int stall_cycles = 0;
    int burst_left   = 0;
    bit gaps_on      = 1'b1;
    int rx_hold_left = 0;

    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            colour_table[i] = 16'h0000;
            known_rgb[i]    = 24'h0;
            known_set[i]    = 1'b0;
        end
    end

    // floor(x * 31 / 255), exact integer form
    function automatic logic [4:0] chan_to_five(input logic [7:0] v);
        int p;
        p = int'(v) * 31 / 255;
        return p[4:0];
    endfunction

    // search the palette and pack the index, pushing any byte that results
    task automatic pack_index(input t_kind kind, input logic [7:0] idx,
                              input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        logic [15:0]   col;
        logic [7:0]    hit;
        int            lim;
        bit            found;
        t_index_result res;
        col = {1'b1, chan_to_five(b), chan_to_five(g), chan_to_five(r)};
        if (kind == KIND_PALETTE_WRITE) begin
            if (int'(idx) < DEPTH)
                colour_table[idx] = col;
            return;
        end
        lim = (cur_format == FMT_8BPP) ? 256 : ENTRIES_4BPP;
        if (lim > DEPTH)
            lim = DEPTH;
        found = 1'b0;
        hit   = 8'd0;
        for (int i = 0; i < lim; i++) begin
            if (!found && colour_table[i] == col) begin
                found = 1'b1;
                hit   = i[7:0];
            end
        end
        if (!found) begin
            held_nibble = 4'd0;
            pair_open   = 1'b0;
            res.packed_byte = 8'h00;
            res.not_found   = 1'b1;
            expected_bytes.push_back(res);
        end else if (cur_format == FMT_8BPP) begin
            held_nibble = 4'd0;
            pair_open   = 1'b0;
            res.packed_byte = hit;
            res.not_found   = 1'b0;
            expected_bytes.push_back(res);
        end else if (!pair_open) begin
            held_nibble = hit[3:0];
            pair_open   = 1'b1;
        end else begin
            res.packed_byte = {hit[3:0], held_nibble};
            res.not_found   = 1'b0;
            expected_bytes.push_back(res);
            held_nibble = 4'd0;
            pair_open   = 1'b0;
        end
    endtask

    // monitor: predict on accepted inputs, check accepted outputs
    always @(posedge i_clk) begin
        t_index_result want;
        bit            moved;
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            moved = 1'b0;
            if (i_cfg_wr_en)
                cur_format = t_fmt'(i_cfg_wr_data);
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                pack_index(t_kind'(i_kind), i_entry_index, i_red, i_green, i_blue);
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (expected_bytes.size() == 0) begin
                    $error("unexpected result: packed_byte %0h not_found %0b",
                           o_packed_byte, o_not_found);
                    err_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_packed_byte !== want.packed_byte) begin
                        $error("packed_byte: expected %0h, got %0h",
                               want.packed_byte, o_packed_byte);
                        err_count++;
                    end
                    if (o_not_found !== want.not_found) begin
                        $error("not_found: expected %0b, got %0b",
                               want.not_found, o_not_found);
                        err_count++;
                    end
                end
            end
            if (moved)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // receiver: long hold-off on request, otherwise a changing stall pattern
    initial begin
        int          rx_mode;
        int          rx_phase_left;
        logic [31:0] rx_pattern;
        rx_mode       = 0;
        rx_phase_left = 0;
        rx_pattern    = 32'h0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_out_ready <= 1'b0;
                rx_hold_left--;
            end else begin
                if (rx_phase_left == 0) begin
                    rx_mode       = $urandom_range(0, 3);
                    rx_pattern    = $urandom;
                    rx_phase_left = $urandom_range(16, 160);
                end
                rx_phase_left--;
                case (rx_mode)
                    0: begin
                        i_out_ready <= 1'b1;
                    end
                    1: begin
                        i_out_ready <= rx_pattern[0];
                        rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
                    end
                    default: begin
                        i_out_ready <= ($urandom_range(0, 99) >= 25);
                    end
                endcase
            end
        end
    end

    // send one transaction, with bursts and gaps between them
    task automatic send_item(input t_kind kind, input logic [7:0] idx,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            // now and then a long run with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_entry_index <= idx;
        i_red         <= r;
        i_green       <= g;
        i_blue        <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_entry(input logic [7:0] idx, input logic [7:0] r,
                               input logic [7:0] g, input logic [7:0] b);
        known_rgb[idx] = {r, g, b};
        known_set[idx] = 1'b1;
        send_item(KIND_PALETTE_WRITE, idx, r, g, b);
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        send_item(KIND_PIXEL, 8'($urandom_range(0, 255)), r, g, b);
    endtask

    // colour of a random entry below lim if it was written, else a random one
    task automatic pick_colour(input int lim, output logic [7:0] r,
                               output logic [7:0] g, output logic [7:0] b);
        int e;
        e = $urandom_range(0, lim - 1);
        if (known_set[e]) begin
            {r, g, b} = known_rgb[e];
        end else begin
            r = 8'($urandom_range(0, 255));
            g = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
        end
    endtask

    // small shift of a channel, which may or may not keep its 5-bit value
    function automatic logic [7:0] nudge(input logic [7:0] v);
        int t;
        t = int'(v) + $urandom_range(0, 6) - 3;
        if (t < 0)
            t = 0;
        if (t > 255)
            t = 255;
        return t[7:0];
    endfunction

    // sender pauses until every result is in, then lets the chain empty
    task automatic drain_and_settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_format(input t_fmt fmt);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= fmt;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic settle_then_set_format(input t_fmt fmt);
        drain_and_settle();
        write_format(fmt);
    endtask

    // every entry invalid after reset, so nothing matches, not even black
    task automatic test_lookup_after_reset();
        settle_then_set_format(FMT_4BPP);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
    endtask

    // palette writes, pairing of nibbles, lowest match and search range
    task automatic test_palette_and_pairs();
        write_entry(8'd0, 8'd0, 8'd0, 8'd0);
        write_entry(8'd1, 8'd255, 8'd255, 8'd255);
        // same 5-bit colour as entry 0, must lose to it
        write_entry(8'd2, 8'd8, 8'd8, 8'd8);
        write_entry(8'd3, 8'd9, 8'd9, 8'd9);
        write_entry(8'd15, 8'd255, 8'd0, 8'd0);
        // outside the 4bpp search range
        write_entry(8'd16, 8'd0, 8'd255, 8'd0);
        write_entry(8'd255, 8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd7, 8'd5, 8'd3);
        send_pixel(8'd255, 8'd0, 8'd0);
        // even pixel found, then a miss clears the half-filled byte
        send_pixel(8'd9, 8'd9, 8'd9);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        // overwrite entry 0, black now resolves to entry 2
        write_entry(8'd0, 8'd100, 8'd100, 8'd100);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd100, 8'd100, 8'd100);
    endtask

    // held nibble survives a format write; an 8bpp pixel discards it
    task automatic test_format_switch();
        settle_then_set_format(FMT_4BPP);
        send_pixel(8'd255, 8'd0, 8'd0);
        drain_and_settle();
        write_format(FMT_8BPP);
        write_format(FMT_4BPP);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        settle_then_set_format(FMT_8BPP);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        settle_then_set_format(FMT_4BPP);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
    endtask

    // receiver holds off while the sender keeps going, so the block backs up
    task automatic test_output_backpressure();
        logic [7:0] r, g, b;
        settle_then_set_format(FMT_8BPP);
        gaps_on      = 1'b0;
        rx_hold_left = HOLD_CYCLES;
        repeat (400) begin
            pick_colour(DEPTH, r, g, b);
            send_pixel(r, g, b);
        end
        gaps_on = 1'b1;
        drain_and_settle();
    endtask

    // mixed palette writes and pixels, mostly colours that hit the palette
    task automatic test_random_traffic(input t_fmt fmt, input int n_items);
        int         lim, sel, e;
        logic [7:0] r, g, b;
        settle_then_set_format(fmt);
        lim = (fmt == FMT_8BPP) ? DEPTH : ENTRIES_4BPP;
        repeat (n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 15) begin
                if (fmt == FMT_4BPP && $urandom_range(0, 9) < 6)
                    e = $urandom_range(0, ENTRIES_4BPP - 1);
                else
                    e = $urandom_range(0, DEPTH - 1);
                write_entry(e[7:0], 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else if (sel < 80) begin
                pick_colour(lim, r, g, b);
                if ($urandom_range(0, 3) == 0) begin
                    r = nudge(r);
                    g = nudge(g);
                    b = nudge(b);
                end
                send_pixel(r, g, b);
            end else begin
                send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
            end
        end
    endtask

    // test sequence
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_lookup_after_reset();
        test_palette_and_pairs();
        test_format_switch();
        test_random_traffic(FMT_4BPP, 180);
        test_random_traffic(FMT_8BPP, 180);
        test_output_backpressure();
        test_random_traffic(FMT_4BPP, 170);
        test_random_traffic(FMT_8BPP, 170);
        test_random_traffic(FMT_4BPP, 170);

        drain_and_settle();
        if (expected_bytes.size() != 0) begin
            $error("%0d results never arrived", expected_bytes.size());
            err_count++;
        end
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/rpip_pkg.sv
sv/rpip_cell.sv
sv/rpip_pack.sv
sv/rgb_palette_index_packer_unit.sv
bench/tb.sv
